/* hw/rtl/rxs_pkg.sv */
`default_nettype none

package rxs_pkg;

	localparam int MAX_RECORDS = 32;
	localparam int AW          = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CW          = $clog2(MAX_RECORDS + 1);

	localparam int ID_W   = 5;
	localparam int TIME_W = 32;
	localparam int VAL_W  = 16;
	localparam int LVL_W  = 3;
	localparam int KEY_W  = LVL_W + TIME_W;
	localparam int DATA_W = 32;
	localparam int PADDR_W = 3;

	// register index, taken from paddr[2]
	localparam logic REG_LIST_KIND = 1'b0;

	localparam logic KIND_DEADLINE = 1'b0;
	localparam logic KIND_DAILY    = 1'b1;

	// daily levels before the alert bonus
	localparam logic [LVL_W-1:0] LVL_REF_HIT   = 3'd3;
	localparam logic [LVL_W-1:0] LVL_REF_MISS  = 3'd0;
	localparam logic [LVL_W-1:0] LVL_FULL      = 3'd2;
	localparam logic [LVL_W-1:0] LVL_PARTIAL   = 3'd1;
	localparam logic [LVL_W-1:0] LVL_ALERT_ADD = 3'd4;

	typedef struct packed {
		logic [ID_W-1:0]   record_id;
		logic              done_req;
		logic              date_known;
		logic [TIME_W-1:0] deadline;
		logic              daily_ref;
		logic [VAL_W-1:0]  current_value;
		logic [VAL_W-1:0]  max_value;
		logic              no_alert;
		logic [TIME_W-1:0] fill_time;
		logic              final_req;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0] sorted_id;
		logic            last_out;
	} out_item_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
	} rec_t;

	typedef enum logic {
		WSEL_REC,
		WSEL_CUR
	} wsel_t;

	typedef struct packed {
		logic          we;
		wsel_t         wsel;
		logic [AW-1:0] waddr;
		logic          re;
		logic [AW-1:0] raddr;
		logic          cur_load;
		logic          cmp;
		logic          load_out;
		logic          out_last;
	} cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/rxs_regs.sv */
`default_nettype none

module rxs_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rxs_pkg::PADDR_W-1:0] paddr,
	input  wire logic [rxs_pkg::DATA_W-1:0]  pwdata,
	output logic      [rxs_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	output logic                             list_kind
);

	logic kind_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == rxs_pkg::REG_LIST_KIND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= rxs_pkg::KIND_DEADLINE;
		end else if (wr_en) begin
			kind_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == rxs_pkg::REG_LIST_KIND) begin
			prdata[0] = kind_q;
		end
	end

	assign list_kind = kind_q;

endmodule

`default_nettype wire

/* hw/rtl/rxs_datapath.sv */
`default_nettype none

module rxs_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               list_kind,
	input  wire rxs_pkg::in_item_t  rec,
	input  wire rxs_pkg::cmd_t      cmd,
	output logic                    out_free,
	output logic                    ord_valid,
	input  wire logic               ord_stall,
	output rxs_pkg::out_item_t      ord
);

	rxs_pkg::rec_t mem [rxs_pkg::MAX_RECORDS];
	rxs_pkg::rec_t rdata_q;
	rxs_pkg::rec_t cur_q;
	rxs_pkg::rec_t in_rec;
	rxs_pkg::rec_t wdata;
	rxs_pkg::out_item_t out_q;
	logic out_valid_q;
	logic swap;
	logic we;
	logic [rxs_pkg::LVL_W-1:0] lvl;

	// a stays ahead of b
	function automatic logic stay_ahead(input logic kind,
		input logic [rxs_pkg::KEY_W-1:0] a, input logic [rxs_pkg::KEY_W-1:0] b);
		logic r;
		if (kind == rxs_pkg::KIND_DEADLINE) begin
			if (a[33] != b[33]) begin
				r = b[33];
			end else if (a[32] != b[32]) begin
				r = a[32];
			end else if (!a[33]) begin
				r = a[31:0] <= b[31:0];
			end else begin
				r = a[31:0] >= b[31:0];
			end
		end else begin
			if (a[34:32] == b[34:32]) begin
				r = a[31:0] <= b[31:0];
			end else begin
				r = a[34:32] > b[34:32];
			end
		end
		return r;
	endfunction

	always_comb begin
		if (rec.daily_ref) begin
			lvl = (rec.current_value == 16'd1) ? rxs_pkg::LVL_REF_HIT : rxs_pkg::LVL_REF_MISS;
		end else begin
			lvl = (rec.current_value == rec.max_value) ? rxs_pkg::LVL_FULL
			                                           : rxs_pkg::LVL_PARTIAL;
		end
		if (!rec.no_alert) begin
			lvl = lvl + rxs_pkg::LVL_ALERT_ADD;
		end
		in_rec.id = rec.record_id;
		if (list_kind == rxs_pkg::KIND_DEADLINE) begin
			in_rec.key = {1'b0, rec.done_req, rec.date_known, rec.deadline};
		end else begin
			in_rec.key = {lvl, rec.fill_time};
		end
	end

	assign swap  = cmd.cmp && !stay_ahead(list_kind, cur_q.key, rdata_q.key);
	assign we    = cmd.we || swap;
	assign wdata = (cmd.wsel == rxs_pkg::WSEL_REC) ? in_rec : cur_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[cmd.waddr] <= wdata;
		end
		if (cmd.re) begin
			rdata_q <= mem[cmd.raddr];
		end
		if (cmd.cur_load || swap) begin
			cur_q <= rdata_q;
		end
		if (cmd.load_out) begin
			out_q.sorted_id <= rdata_q.id;
			out_q.last_out  <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!ord_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_free  = !out_valid_q || !ord_stall;
	assign ord_valid = out_valid_q;
	assign ord       = out_q;

endmodule

`default_nettype wire

/* hw/rtl/rxs_ctrl.sv */
`default_nettype none

module rxs_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rec_valid,
	input  wire logic          final_req,
	output logic               rec_stall,
	input  wire logic          out_free,
	output rxs_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_I,
		S_CUR,
		S_CMP,
		S_WB,
		S_OUT_RD,
		S_OUT_LD
	} state_t;

	state_t state_q;
	logic [rxs_pkg::CW-1:0] count_q;
	logic [rxs_pkg::AW-1:0] i_q;
	logic [rxs_pkg::AW-1:0] j_q;
	logic [rxs_pkg::AW-1:0] k_q;
	logic [rxs_pkg::CW-1:0] count_inc;
	logic [rxs_pkg::CW-1:0] i_ext;
	logic [rxs_pkg::CW-1:0] j_ext;
	logic [rxs_pkg::CW-1:0] k_ext;
	logic has_room;
	logic accept;
	logic out_last;

	assign rec_stall = (state_q != S_IDLE);
	assign accept    = rec_valid && !rec_stall;
	assign has_room  = count_q < rxs_pkg::CW'(rxs_pkg::MAX_RECORDS);
	assign count_inc = has_room ? count_q + rxs_pkg::CW'(1) : count_q;
	assign i_ext     = rxs_pkg::CW'(i_q);
	assign j_ext     = rxs_pkg::CW'(j_q);
	assign k_ext     = rxs_pkg::CW'(k_q);
	assign out_last  = (k_ext + rxs_pkg::CW'(1)) == count_q;

	always_comb begin
		cmd          = '0;
		cmd.wsel     = rxs_pkg::WSEL_CUR;
		cmd.out_last = out_last;
		case (state_q)
			S_IDLE: begin
				cmd.we    = accept && has_room;
				cmd.wsel  = rxs_pkg::WSEL_REC;
				cmd.waddr = count_q[rxs_pkg::AW-1:0];
			end
			S_RD_I: begin
				cmd.re    = 1'b1;
				cmd.raddr = i_q;
			end
			S_CUR: begin
				cmd.cur_load = 1'b1;
				cmd.re       = 1'b1;
				cmd.raddr    = i_q + rxs_pkg::AW'(1);
			end
			S_CMP: begin
				// write-back of the swapped entry is gated by the compare result
				cmd.cmp   = 1'b1;
				cmd.waddr = j_q;
				cmd.re    = 1'b1;
				cmd.raddr = j_q + rxs_pkg::AW'(1);
			end
			S_WB: begin
				cmd.we    = 1'b1;
				cmd.waddr = i_q;
			end
			S_OUT_RD: begin
				cmd.re    = 1'b1;
				cmd.raddr = k_q;
			end
			S_OUT_LD: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= count_inc;
						i_q     <= '0;
						k_q     <= '0;
						if (final_req) begin
							state_q <= (count_inc >= rxs_pkg::CW'(2)) ? S_RD_I : S_OUT_RD;
						end
					end
				end
				S_RD_I: begin
					state_q <= S_CUR;
				end
				S_CUR: begin
					j_q     <= i_q + rxs_pkg::AW'(1);
					state_q <= S_CMP;
				end
				S_CMP: begin
					if ((j_ext + rxs_pkg::CW'(1)) < count_q) begin
						j_q <= j_q + rxs_pkg::AW'(1);
					end else begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					i_q <= i_q + rxs_pkg::AW'(1);
					if ((i_ext + rxs_pkg::CW'(2)) < count_q) begin
						state_q <= S_RD_I;
					end else begin
						state_q <= S_OUT_RD;
					end
				end
				S_OUT_RD: begin
					state_q <= S_OUT_LD;
				end
				S_OUT_LD: begin
					if (out_free) begin
						if (out_last) begin
							count_q <= '0;
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + rxs_pkg::AW'(1);
							state_q <= S_OUT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/record_exchange_sorter.sv */
// Non-final items are taken back to back while loading; after the final item the
// held records are exchange-sorted, one compare per cycle through the one-read
// one-write record memory, each pass reading its first entry, comparing it with
// every later entry and writing it back. Results then leave one id at a time, each
// read from memory and then loaded into the output register, which waits while the
// output is stalled. Reset: control, record count and the mode register
// (deadline ordering) clear at once; the record memory is not cleared.
`default_nettype none

module record_exchange_sorter (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rxs_pkg::PADDR_W-1:0] paddr,
	input  wire logic [rxs_pkg::DATA_W-1:0]  pwdata,
	output logic      [rxs_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	input  wire logic                        rec_valid,
	output logic                             rec_stall,
	input  wire rxs_pkg::in_item_t           rec,
	output logic                             ord_valid,
	input  wire logic                        ord_stall,
	output rxs_pkg::out_item_t               ord
);

	logic          list_kind;
	logic          out_free;
	rxs_pkg::cmd_t cmd;

	rxs_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.list_kind (list_kind)
	);

	rxs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.final_req (rec.final_req),
		.rec_stall (rec_stall),
		.out_free  (out_free),
		.cmd       (cmd)
	);

	rxs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.list_kind (list_kind),
		.rec       (rec),
		.cmd       (cmd),
		.out_free  (out_free),
		.ord_valid (ord_valid),
		.ord_stall (ord_stall),
		.ord       (ord)
	);

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import rxs_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 8;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]    pwdata;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	logic                 rec_valid;
	logic                 rec_stall;
	in_item_t             rec;
	logic                 ord_valid;
	logic                 ord_stall = 1'b0;
	out_item_t            ord;

	record_exchange_sorter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.rec_valid(rec_valid),
		.rec_stall(rec_stall),
		.rec      (rec),
		.ord_valid(ord_valid),
		.ord_stall(ord_stall),
		.ord      (ord)
	);

	// shadow of the block: held batch and mode register
	logic [KEY_W-1:0] held_keys [MAX_RECORDS];
	logic [ID_W-1:0]  held_ids  [MAX_RECORDS];
	int               held_count;
	logic             kind_shadow;
	out_item_t        sorted_queue [$];

	int idle_pct;
	int stall_pct;
	int errors;
	int cycles;
	int records_sent;
	int ids_checked;
	int batches_sorted;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	always @(posedge clk)
		ord_stall <= ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin
		if (ord_valid && !ord_stall) begin
			ids_checked++;
			if (sorted_queue.size() == 0) begin
				$error("sorted_id: expected none, actual %0d", ord.sorted_id);
				errors++;
			end else begin
				out_item_t want;
				want = sorted_queue.pop_front();
				if (ord.sorted_id !== want.sorted_id) begin
					$error("sorted_id: expected %0d, actual %0d", want.sorted_id,
						ord.sorted_id);
					errors++;
				end
				if (ord.last_out !== want.last_out) begin
					$error("last_out: expected %0d, actual %0d", want.last_out,
						ord.last_out);
					errors++;
				end
			end
		end
	end

	function automatic logic [KEY_W-1:0] record_key(in_item_t r, logic kind);
		logic [LVL_W-1:0] lvl;
		if (kind == KIND_DEADLINE)
			return {1'b0, r.done_req, r.date_known, r.deadline};
		if (r.daily_ref)
			lvl = (r.current_value == 16'd1) ? LVL_REF_HIT : LVL_REF_MISS;
		else
			lvl = (r.current_value == r.max_value) ? LVL_FULL : LVL_PARTIAL;
		if (!r.no_alert)
			lvl = lvl + LVL_ALERT_ADD;
		return {lvl, r.fill_time};
	endfunction

	// true when record a may stay ahead of record b
	function automatic bit may_lead(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b, logic kind);
		if (kind == KIND_DEADLINE) begin
			if (a[33] != b[33])
				return b[33];
			if (a[32] != b[32])
				return a[32];
			if (!a[33])
				return a[31:0] <= b[31:0];
			return a[31:0] >= b[31:0];
		end
		if (a[34:32] == b[34:32])
			return a[31:0] <= b[31:0];
		return a[34:32] > b[34:32];
	endfunction

	task automatic absorb_record(in_item_t r);
		logic [KEY_W-1:0] tk;
		logic [ID_W-1:0]  ti;
		out_item_t        o;
		if (held_count < MAX_RECORDS) begin
			held_keys[held_count] = record_key(r, kind_shadow);
			held_ids[held_count]  = r.record_id;
			held_count++;
		end
		if (!r.final_req)
			return;
		for (int i = 0; i + 1 < held_count; i++)
			for (int j = i + 1; j < held_count; j++)
				if (!may_lead(held_keys[i], held_keys[j], kind_shadow)) begin
					tk = held_keys[i];
					ti = held_ids[i];
					held_keys[i] = held_keys[j];
					held_ids[i]  = held_ids[j];
					held_keys[j] = tk;
					held_ids[j]  = ti;
				end
		for (int k = 0; k < held_count; k++) begin
			o.sorted_id = held_ids[k];
			o.last_out  = (k + 1 == held_count);
			sorted_queue.push_back(o);
		end
		held_count = 0;
		batches_sorted++;
	endtask

	task automatic send_record(in_item_t r);
		while ($urandom_range(0, 99) < idle_pct) begin
			rec_valid <= 1'b0;
			@(posedge clk);
		end
		rec_valid <= 1'b1;
		rec       <= r;
		@(posedge clk);
		while (rec_stall)
			@(posedge clk);
		records_sent++;
		absorb_record(r);
	endtask

	task automatic wait_idle();
		rec_valid <= 1'b0;
		@(posedge clk);
		while (sorted_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_list_kind(logic kind);
		logic [PADDR_W-1:0] addr;
		addr = PADDR_W'({REG_LIST_KIND, 2'b00});
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {$urandom_range(0, 1) ? 31'h7fffffff : 31'h0, kind};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		kind_shadow = kind;
		// read back
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[0] !== kind) begin
			$error("list_kind: expected %0d, actual %0d", kind, prdata[0]);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic in_item_t random_record();
		in_item_t r;
		r.record_id  = 5'($urandom);
		r.done_req   = 1'($urandom);
		r.date_known = 1'($urandom);
		r.daily_ref  = 1'($urandom);
		r.no_alert   = 1'($urandom);
		r.max_value  = ($urandom_range(0, 5) == 0) ? 16'hffff : 16'($urandom);
		case ($urandom_range(0, 4))
			0: r.current_value = 16'd0;
			1: r.current_value = 16'd1;
			2: r.current_value = r.max_value;
			default: r.current_value = 16'($urandom);
		endcase
		// narrow times so equal keys and ties come up often
		case ($urandom_range(0, 3))
			0: r.deadline = 32'($urandom_range(0, 3));
			1: r.deadline = 32'hffffffff - 32'($urandom_range(0, 1));
			default: r.deadline = $urandom;
		endcase
		case ($urandom_range(0, 3))
			0: r.fill_time = 32'($urandom_range(0, 3));
			1: r.fill_time = 32'hffffffff - 32'($urandom_range(0, 1));
			default: r.fill_time = $urandom;
		endcase
		r.final_req = 1'b0;
		return r;
	endfunction

	task automatic send_batch(int n);
		in_item_t r;
		for (int i = 0; i < n; i++) begin
			r = random_record();
			r.final_req = (i == n - 1);
			send_record(r);
		end
	endtask

	task automatic test_deadline_order();
		in_item_t r;
		bit [1:0] flags [8] = '{2'b00, 2'b01, 2'b10, 2'b11, 2'b01, 2'b11, 2'b00, 2'b10};
		logic [31:0] dl [8] = '{32'd0, 32'hffffffff, 32'd0, 32'hffffffff,
			32'd0, 32'd0, 32'd7, 32'd7};
		wait_idle();
		set_list_kind(KIND_DEADLINE);
		for (int i = 0; i < 8; i++) begin
			r = random_record();
			r.record_id  = 5'(i * 4 + 3);
			r.done_req   = flags[i][1];
			r.date_known = flags[i][0];
			r.deadline   = dl[i];
			r.final_req  = (i == 7);
			send_record(r);
		end
	endtask

	task automatic test_daily_order();
		in_item_t r;
		wait_idle();
		set_list_kind(KIND_DAILY);
		// walk the ref hit, full and partial levels, with and without alert
		for (int i = 0; i < 8; i++) begin
			r = random_record();
			r.record_id     = 5'(31 - i);
			r.daily_ref     = i[0];
			r.no_alert      = i[1];
			r.max_value     = i[2] ? 16'hffff : 16'd0;
			r.current_value = i[0] ? 16'd1 : (i[2] ? 16'hffff : 16'd5);
			if (i == 6)
				r.current_value = 16'hfffe;
			r.fill_time     = i[2] ? 32'hffffffff : 32'd0;
			r.final_req     = (i == 7);
			send_record(r);
		end
	endtask

	task automatic test_single_record();
		wait_idle();
		send_batch(1);
		wait_idle();
		set_list_kind(KIND_DEADLINE);
		send_batch(2);
	endtask

	task automatic test_mode_switch_in_batch();
		in_item_t r;
		wait_idle();
		set_list_kind(KIND_DEADLINE);
		for (int i = 0; i < 4; i++) begin
			r = random_record();
			send_record(r);
		end
		wait_idle();
		set_list_kind(KIND_DAILY);
		send_batch(4);
	endtask

	task automatic test_over_capacity();
		wait_idle();
		set_list_kind(KIND_DEADLINE);
		send_batch(MAX_RECORDS + 3);
		wait_idle();
		set_list_kind(KIND_DAILY);
		send_batch(MAX_RECORDS + 1);
		wait_idle();
		send_batch(MAX_RECORDS);
	endtask

	task automatic test_random_batches(int idle, int stall, int n_items);
		int sent;
		int n;
		idle_pct  = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < n_items) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, MAX_RECORDS)
				: $urandom_range(1, 8);
			send_batch(n);
			sent += n;
			if ($urandom_range(0, 2) == 0) begin
				// hold off until the whole batch has come out
				wait_idle();
				if ($urandom_range(0, 1) == 0)
					set_list_kind(1'($urandom));
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		rec_valid = 1'b0;
		rec       = '0;
		idle_pct  = 0;
		stall_pct = 0;
		errors    = 0;
		cycles    = 0;
		records_sent   = 0;
		ids_checked    = 0;
		batches_sorted = 0;
		held_count     = 0;
		kind_shadow    = KIND_DEADLINE;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset value of the mode register is deadline ordering
		send_batch(3);
		test_deadline_order();
		test_daily_order();
		test_single_record();
		test_mode_switch_in_batch();
		test_over_capacity();

		test_random_batches(0, 0, 80);
		test_random_batches(69, 0, 80);
		test_random_batches(0, 69, 80);
		test_random_batches(21, 21, 80);

		stall_pct = 0;
		wait_idle();
		repeat (50) @(posedge clk);
		$display("covered %0d records in %0d sorted batches, %0d ids checked,",
			records_sent, batches_sorted, ids_checked);
		$display("both orderings, mode switch inside a batch, overfull batches");
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
